[sv/rsc_pkg.sv]
// Shared types and constants of the rotor substitution cipher core.
// Holds the request and response payload structs and the register and field codes.
// No dependencies.
package rsc_pkg;

   localparam int RotorCount = 3;

   localparam int LetterW = 5;
   localparam int RotorW  = 2;
   localparam int ShiftW  = 5;
   localparam int CsrDataW = 5;

   localparam logic [LetterW-1:0] Alpha = 5'd26;

   localparam logic KindLoad   = 1'b0;
   localparam logic KindLetter = 1'b1;

   localparam logic ModeEncode = 1'b0;
   localparam logic ModeDecode = 1'b1;

   typedef enum logic [0:0] {
      CSR_MODE  = 1'b0,
      CSR_SHIFT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               kind;
      logic [RotorW-1:0]  rotor;
      logic [LetterW-1:0] slot;
      logic [LetterW-1:0] letter;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [LetterW-1:0] result_letter;
      logic               result_last;
   } rsp_type;

endpackage

[sv/rsc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// No dependencies.
module rsc_ram #(
   parameter int Width = 5,
   parameter int Depth = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rotor_substitution_cipher_core.sv]
// Top level of the rotor substitution cipher core.
// Depends on rsc_pkg for payload types and codes, and on rsc_ram for the rotor tables.
//
// Usage:
// Requests arrive on the req_ channel (valid/ready). A load request writes one entry of
// one rotor into both the forward and the inverse table. A letter request is encoded or
// decoded according to the mode register and yields exactly one response on rsp_; loads
// yield none. Registers mode and shift are written on the csr_ channel, which is always
// ready; write them only while no request is in flight.
// Every request walks a pipeline of ROTOR_COUNT stages, one per rotor table bank, each
// doing one synchronous read, followed by the response register. A letter passes every
// stage and the response register before it appears on rsp_, and one request per cycle
// is sustained while the receiver keeps up. Load requests write their bank as they pass
// the stage that owns it, so table updates stay in request order with letter reads.
// When the receiver stalls, the response register holds and the stages behind it fill up
// one by one; req_ready drops only once every stage is occupied.
// Reset clears the message position, the registers and all valid flags. The tables are
// not cleared and must be loaded with full permutations before letters are sent.
module rotor_substitution_cipher_core #(
   parameter int ROTOR_COUNT = rsc_pkg::RotorCount
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rsc_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rsc_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  rsc_pkg::csr_index_type        csr_index,
   input  logic [rsc_pkg::CsrDataW-1:0]  csr_data
);

   localparam int LW = rsc_pkg::LetterW;

   typedef struct packed {
      logic                       is_letter;
      logic                       good;
      logic [rsc_pkg::RotorW-1:0] rotor;
      logic [LW-1:0]              slot;
      logic [LW-1:0]              letter;
      logic                       mode;
      logic                       last;
      logic [LW-1:0]              offset;
   } stage_type;

   logic                        mode_ff;
   logic [rsc_pkg::ShiftW-1:0]  shift_ff;
   logic [LW-1:0]               pos_ff;

   logic [ROTOR_COUNT-1:0] valid_ff;
   logic [ROTOR_COUNT-1:0] move;
   logic [ROTOR_COUNT-1:0] load;
   stage_type              stage_ff [ROTOR_COUNT];
   stage_type              stage_in [ROTOR_COUNT];
   logic [LW-1:0]          addr     [ROTOR_COUNT];
   logic [LW-1:0]          fwd_q    [ROTOR_COUNT];
   logic [LW-1:0]          inv_q    [ROTOR_COUNT];
   logic [LW-1:0]          data     [ROTOR_COUNT];

   logic             rsp_valid_ff;
   rsc_pkg::rsp_type rsp_ff;
   rsc_pkg::rsp_type rsp_in;
   logic             out_free;

   logic [LW-1:0] shift_mod;
   logic [LW:0]   off_sum;
   logic [LW-1:0] offset;
   logic [LW-1:0] letter_mod;
   logic [LW:0]   enc_sum;
   logic [LW-1:0] enc_addr;
   stage_type     entry;
   logic          req_fire;
   logic [LW-1:0] final_v;
   logic [LW-1:0] final_off;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !valid_ff[0] || move[0];
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      shift_mod  = (shift_ff >= rsc_pkg::Alpha) ? shift_ff - rsc_pkg::Alpha : shift_ff;
      off_sum    = {1'b0, shift_mod} + {1'b0, pos_ff};
      offset     = (off_sum >= {1'b0, rsc_pkg::Alpha}) ?
                   LW'(off_sum - {1'b0, rsc_pkg::Alpha}) : off_sum[LW-1:0];
      letter_mod = (req_payload.letter >= rsc_pkg::Alpha) ?
                   req_payload.letter - rsc_pkg::Alpha : req_payload.letter;
      enc_sum    = {1'b0, letter_mod} + {1'b0, offset};
      enc_addr   = (enc_sum >= {1'b0, rsc_pkg::Alpha}) ?
                   LW'(enc_sum - {1'b0, rsc_pkg::Alpha}) : enc_sum[LW-1:0];

      entry.is_letter = (req_payload.kind == rsc_pkg::KindLetter);
      entry.good      = (int'(req_payload.rotor) < ROTOR_COUNT) &&
                        (req_payload.slot < rsc_pkg::Alpha) &&
                        (req_payload.letter < rsc_pkg::Alpha);
      entry.rotor     = req_payload.rotor;
      entry.slot      = req_payload.slot;
      entry.letter    = req_payload.letter;
      entry.mode      = mode_ff;
      entry.last      = req_payload.last;
      entry.offset    = offset;
   end

   always_comb begin
      move[ROTOR_COUNT-1] = valid_ff[ROTOR_COUNT-1] &&
                            (!stage_ff[ROTOR_COUNT-1].is_letter || out_free);
      for (int k = ROTOR_COUNT - 2; k >= 0; k--) begin
         move[k] = valid_ff[k] && (!valid_ff[k+1] || move[k+1]);
      end
   end

   for (genvar k = 0; k < ROTOR_COUNT; k++) begin : g_stage
      logic fwd_we;
      logic inv_we;

      if (k == 0) begin : g_first
         assign stage_in[k] = entry;
         assign addr[k]     = (mode_ff == rsc_pkg::ModeDecode) ? letter_mod : enc_addr;
         assign load[k]     = req_fire;
      end else begin : g_next
         assign stage_in[k] = stage_ff[k-1];
         assign addr[k]     = data[k-1];
         assign load[k]     = move[k-1];
      end

      assign fwd_we = load[k] && !stage_in[k].is_letter && stage_in[k].good &&
                      (int'(stage_in[k].rotor) == k);
      assign inv_we = load[k] && !stage_in[k].is_letter && stage_in[k].good &&
                      (int'(stage_in[k].rotor) == ROTOR_COUNT - 1 - k);
      assign data[k] = (stage_ff[k].mode == rsc_pkg::ModeDecode) ? inv_q[k] : fwd_q[k];

      rsc_ram #(
         .Width (LW),
         .Depth (int'(rsc_pkg::Alpha))
      ) u_fwd_ram (
         .clock   (clock),
         .wr_en   (fwd_we),
         .wr_addr (stage_in[k].slot),
         .wr_data (stage_in[k].letter),
         .rd_en   (load[k]),
         .rd_addr (addr[k]),
         .rd_data (fwd_q[k])
      );

      rsc_ram #(
         .Width (LW),
         .Depth (int'(rsc_pkg::Alpha))
      ) u_inv_ram (
         .clock   (clock),
         .wr_en   (inv_we),
         .wr_addr (stage_in[k].letter),
         .wr_data (stage_in[k].slot),
         .rd_en   (load[k]),
         .rd_addr (addr[k]),
         .rd_data (inv_q[k])
      );
   end

   always_comb begin
      final_v   = data[ROTOR_COUNT-1];
      final_off = stage_ff[ROTOR_COUNT-1].offset;
      if (stage_ff[ROTOR_COUNT-1].mode == rsc_pkg::ModeDecode) begin
         rsp_in.result_letter = (final_v >= final_off) ? final_v - final_off :
                                LW'({1'b0, final_v} + {1'b0, rsc_pkg::Alpha} -
                                    {1'b0, final_off});
      end else begin
         rsp_in.result_letter = final_v;
      end
      rsp_in.result_last = stage_ff[ROTOR_COUNT-1].last;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROTOR_COUNT; k++) begin
         if (load[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
      if (out_free) begin
         rsp_ff <= rsp_in;
      end

      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         mode_ff      <= rsc_pkg::ModeEncode;
         shift_ff     <= '0;
      end else begin
         for (int k = 0; k < ROTOR_COUNT; k++) begin
            if (load[k]) begin
               valid_ff[k] <= 1'b1;
            end else if (move[k]) begin
               valid_ff[k] <= 1'b0;
            end
         end
         if (out_free) begin
            rsp_valid_ff <= move[ROTOR_COUNT-1] && stage_ff[ROTOR_COUNT-1].is_letter;
         end
         if (req_fire && entry.is_letter) begin
            if (req_payload.last || pos_ff == rsc_pkg::Alpha - 5'd1) begin
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 5'd1;
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rsc_pkg::CSR_MODE: begin
                  mode_ff <= csr_data[0];
               end
               rsc_pkg::CSR_SHIFT: begin
                  shift_ff <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[dv/tb_rotor_substitution_cipher_core.sv]
// Self-checking testbench for rotor_substitution_cipher_core: rotor loads, letter traffic
// and register writes under random idling and backpressure, checked against a predictor.
// Depends on rsc_pkg and the core RTL.
module tb_rotor_substitution_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Letters     = int'(rsc_pkg::Alpha);
   localparam int RandomItems = 700;
   localparam int HoldCycles  = 120;
   localparam int StallLimit  = 2000;
   localparam int PlanRows    = 25;

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_op_type;

   typedef struct packed {
      row_op_type                   op;
      logic [rsc_pkg::CsrDataW-1:0] mode_data;
      logic [rsc_pkg::CsrDataW-1:0] shift_data;
      logic                         kind;
      logic [rsc_pkg::RotorW-1:0]   rotor;
      logic [rsc_pkg::LetterW-1:0]  slot;
      logic [rsc_pkg::LetterW-1:0]  letter;
      logic                         last;
      logic                         typed;
      logic [rsc_pkg::LetterW-1:0]  want;
   } plan_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   rsc_pkg::req_type             req_payload = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   rsc_pkg::rsp_type             rsp_payload;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   rsc_pkg::csr_index_type       csr_index = rsc_pkg::CSR_MODE;
   logic [rsc_pkg::CsrDataW-1:0] csr_data = '0;

   logic idle_en = 1'b0;
   logic hold_req = 1'b0;

   logic [rsc_pkg::LetterW-1:0] fwd_map [rsc_pkg::RotorCount][Letters];
   logic [rsc_pkg::LetterW-1:0] inv_map [rsc_pkg::RotorCount][Letters];
   logic [rsc_pkg::LetterW-1:0] perm_buf [Letters];
   logic                        cfg_mode = rsc_pkg::ModeEncode;
   logic [rsc_pkg::ShiftW-1:0]  cfg_shift = '0;
   int                          msg_pos = 0;

   rsc_pkg::rsp_type pending_letters [$];
   rsc_pkg::rsp_type rsp_want;
   int               error_count = 0;
   int               item_count = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;
   int               stall_cycles = 0;

   plan_row_type directed_plan [PlanRows] = '{
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd0, 1'b0, 1'b1, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd25, 1'b0, 1'b1, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd3, 5'd31, 5'd31, 1'b0, 1'b1, 5'd7},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd26, 1'b1, 1'b1, 5'd3},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd3, 5'd0, 5'd5, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd31, 5'd5, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd1, 5'd4, 5'd31, 1'b1, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd13, 1'b1, 1'b1, 5'd13},
      '{ROW_WRITE, 5'd0, 5'd25, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd1, 1'b0, 1'b1, 5'd0},
      '{ROW_WRITE, 5'd0, 5'd31, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd0, 1'b1, 1'b1, 5'd6},
      '{ROW_WRITE, 5'd1, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd10, 1'b0, 1'b1, 5'd10},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd0, 1'b0, 1'b1, 5'd25},
      '{ROW_WRITE, 5'd30, 5'd3, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd20, 1'b1, 1'b1, 5'd25},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd5, 5'd7, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd2, 1'b0, 1'b0, 5'd0},
      '{ROW_WRITE, 5'd1, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd7, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLetter, 2'd0, 5'd0, 5'd5, 1'b1, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd5, 5'd5, 1'b0, 1'b0, 5'd0},
      '{ROW_REQUEST, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd7, 5'd7, 1'b0, 1'b0, 5'd0},
      '{ROW_WRITE, 5'd0, 5'd0, rsc_pkg::KindLoad, 2'd0, 5'd0, 5'd0, 1'b0, 1'b0, 5'd0}
   };

   rotor_substitution_cipher_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void flag_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t ns: %s", $time, what);
      end
   endfunction

   function automatic bit cipher_step(input rsc_pkg::req_type r, output rsc_pkg::rsp_type y,
                                      output bit took);
      int v;
      int s;
      int k;
      y = '0;
      took = 1'b0;
      if (r.kind == rsc_pkg::KindLoad) begin
         if (int'(r.rotor) < rsc_pkg::RotorCount && r.slot < rsc_pkg::Alpha &&
             r.letter < rsc_pkg::Alpha) begin
            fwd_map[r.rotor][r.slot] = r.letter;
            inv_map[r.rotor][r.letter] = r.slot;
            took = 1'b1;
         end
         return 1'b0;
      end
      took = 1'b1;
      v = int'(r.letter) % Letters;
      s = int'(cfg_shift) % Letters;
      if (cfg_mode == rsc_pkg::ModeEncode) begin
         v = (v + s + msg_pos) % Letters;
         for (k = 0; k < rsc_pkg::RotorCount; k++) begin
            v = int'(fwd_map[k][v]);
         end
      end else begin
         for (k = rsc_pkg::RotorCount - 1; k >= 0; k--) begin
            v = int'(inv_map[k][v]);
         end
         v = (v + 2 * Letters - s - msg_pos) % Letters;
      end
      y.result_letter = v[rsc_pkg::LetterW-1:0];
      y.result_last = r.last;
      msg_pos = r.last ? 0 : (msg_pos + 1) % Letters;
      return 1'b1;
   endfunction

   task automatic send_req(input rsc_pkg::req_type p, input bit typed,
                           input logic [rsc_pkg::LetterW-1:0] want);
      rsc_pkg::rsp_type y;
      bit               took;
      if (idle_en && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      if (cipher_step(p, y, took)) begin
         if (typed) begin
            y.result_letter = want;
         end
         pending_letters.push_back(y);
      end
      if (took) begin
         item_count++;
      end
   endtask

   task automatic send_load(input int rotor, input int slot, input int letter);
      rsc_pkg::req_type p;
      p = '0;
      p.kind = rsc_pkg::KindLoad;
      p.rotor = rotor[rsc_pkg::RotorW-1:0];
      p.slot = slot[rsc_pkg::LetterW-1:0];
      p.letter = letter[rsc_pkg::LetterW-1:0];
      p.last = 1'($urandom_range(1));
      send_req(p, 1'b0, '0);
   endtask

   task automatic send_letter(input int letter, input bit last);
      rsc_pkg::req_type p;
      p.kind = rsc_pkg::KindLetter;
      p.rotor = rsc_pkg::RotorW'($urandom_range(3));
      p.slot = rsc_pkg::LetterW'($urandom_range(31));
      p.letter = letter[rsc_pkg::LetterW-1:0];
      p.last = last;
      send_req(p, 1'b0, '0);
   endtask

   task automatic load_rotor(input int rotor, input bit scramble);
      int i;
      int j;
      logic [rsc_pkg::LetterW-1:0] tmp;
      for (i = 0; i < Letters; i++) begin
         perm_buf[i] = i[rsc_pkg::LetterW-1:0];
      end
      if (scramble) begin
         for (i = Letters - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = perm_buf[i];
            perm_buf[i] = perm_buf[j];
            perm_buf[j] = tmp;
         end
      end
      for (i = 0; i < Letters; i++) begin
         send_load(rotor, i, int'(perm_buf[i]));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_letters.size() != 0) @(posedge clock);
      repeat (rsc_pkg::RotorCount + 3) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [rsc_pkg::CsrDataW-1:0] mode_data,
                                 input logic [rsc_pkg::CsrDataW-1:0] shift_data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= rsc_pkg::CSR_MODE;
      csr_data <= mode_data;
      do @(posedge clock); while (!csr_ready);
      cfg_mode = mode_data[0];
      csr_index <= rsc_pkg::CSR_SHIFT;
      csr_data <= shift_data;
      do @(posedge clock); while (!csr_ready);
      cfg_shift = shift_data[rsc_pkg::ShiftW-1:0];
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_letters.size() == 0) begin
            flag_error($sformatf("unexpected response letter=%0d last=%0b",
                                 rsp_payload.result_letter, rsp_payload.result_last));
         end else begin
            rsp_want = pending_letters.pop_front();
            if (rsp_payload.result_letter !== rsp_want.result_letter ||
                rsp_payload.result_last !== rsp_want.result_last) begin
               flag_error($sformatf("expected letter=%0d last=%0b, got letter=%0d last=%0b",
                                    rsp_want.result_letter, rsp_want.result_last,
                                    rsp_payload.result_letter, rsp_payload.result_last));
            end
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_left = HoldCycles - 1;
         hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_en && $urandom_range(99) < 18);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      rsc_pkg::req_type p;
      int               target;
      int               phase_num;
      int               burst;
      int               roll;
      int               shift_pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < rsc_pkg::RotorCount; r++) begin
         load_rotor(r, 1'b0);
      end

      foreach (directed_plan[i]) begin
         if (directed_plan[i].op == ROW_WRITE) begin
            apply_settings(directed_plan[i].mode_data, directed_plan[i].shift_data);
         end else begin
            p.kind = directed_plan[i].kind;
            p.rotor = directed_plan[i].rotor;
            p.slot = directed_plan[i].slot;
            p.letter = directed_plan[i].letter;
            p.last = directed_plan[i].last;
            send_req(p, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // The first phases run with no idling on either side.
      target = item_count + RandomItems;
      phase_num = 0;
      while (item_count < target) begin
         idle_en <= (phase_num >= 3);
         case ($urandom_range(5))
            0:       shift_pick = 0;
            1:       shift_pick = 25;
            2:       shift_pick = $urandom_range(26, 31);
            default: shift_pick = $urandom_range(25);
         endcase
         apply_settings(rsc_pkg::CsrDataW'($urandom_range(31)),
                        shift_pick[rsc_pkg::CsrDataW-1:0]);
         if (phase_num < rsc_pkg::RotorCount) begin
            load_rotor(phase_num, 1'b1);
         end else if ($urandom_range(2) == 0) begin
            load_rotor($urandom_range(rsc_pkg::RotorCount - 1), 1'b1);
         end
         if (phase_num == 5) begin
            hold_req <= 1'b1;
         end
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
               send_load($urandom_range(3), $urandom_range(31), $urandom_range(31));
            end else if (roll < 14) begin
               send_letter($urandom_range(26, 31), $urandom_range(7) == 0);
            end else begin
               send_letter($urandom_range(25), $urandom_range(7) == 0);
            end
         end
         phase_num++;
      end

      settle();
      if (error_count == 0 && pending_letters.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
